// ----- src/gda_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types and constants of the grouped decimal aggregator.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int GROUPS   = 1024;
  localparam int GROUP_AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // Largest and smallest sums that fit in 38 decimal digits
  localparam logic [127:0] SUM_MAX = 128'h4B3B4CA85A86C47A_098A223FFFFFFFFF;
  localparam logic [127:0] SUM_MIN = 128'hB4C4B357A5793B85_F675DDC000000001;

  typedef enum logic [1:0] {
    KIND_ACC        = 2'd0,
    KIND_READ       = 2'd1,
    KIND_READ_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    MODE_SUM   = 3'd0,
    MODE_MIN   = 3'd1,
    MODE_MAX   = 3'd2,
    MODE_FIRST = 3'd3,
    MODE_LAST  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic [31:0] count;
    logic        seen;
    logic [63:0] high;
    logic [63:0] low;
  } entry_t;

endpackage

// ----- src/gda_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/grouped_decimal_aggregator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_decimal_aggregator
// Per-group sum, min, max, first or last of 128-bit signed decimal units.
// ----------------------------------------------------------------------------
// For every item the group entry is read from the state RAM in the cycle
// the item is accepted and is updated and written back in the next, so the
// single RAM with its registered read lets no new item in before the last
// is done. A read item waits in the update state while an earlier result is
// still held on the output. After reset the block sweeps the state RAM to
// zero, one group per cycle, and accepts no item until the sweep is done;
// configuration writes are taken at any time.
module grouped_decimal_aggregator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_wr_data,  // agg_mode
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,      // group_id, value_high, value_low, zero pad
  input  logic [2:0]   s_tuser,      // kind, is_null
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,      // result_high, result_low, row_count
  output logic [1:0]   m_tuser       // result_seen, overflowed
);

  localparam int EW = $bits(gda_pkg::entry_t);

  gda_pkg::state_t state, state_next;
  logic [2:0]      agg_mode;
  logic            overflow_flag;
  logic [gda_pkg::GROUP_AW-1:0] clr_addr;

  // latched item
  logic [1:0]  item_kind;
  logic [9:0]  item_gid;
  logic [63:0] item_vh;
  logic [63:0] item_vl;
  logic        item_null;

  logic                         ram_we, ram_re;
  logic [gda_pkg::GROUP_AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0]                ram_wdata, ram_rdata;
  gda_pkg::entry_t              rd_entry, upd_entry;

  logic         item_accept, apply_go, item_is_read, group_ok, clear_last;
  logic [127:0] acc_val, row_val, sum_val, new_val;
  logic         sum_wrap, sum_bad, row_less, row_more;
  logic         do_acc, do_upd, take, set_ovf;

  gda_ram #(
    .WIDTH(EW),
    .DEPTH(gda_pkg::GROUPS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry     = gda_pkg::entry_t'(ram_rdata);
  assign item_accept  = s_tvalid && s_tready;
  assign item_is_read = (item_kind == gda_pkg::KIND_READ) ||
                        (item_kind == gda_pkg::KIND_READ_CLEAR);
  assign group_ok     = 32'(item_gid) < 32'(gda_pkg::GROUPS);
  assign clear_last   = clr_addr == gda_pkg::GROUP_AW'(gda_pkg::GROUPS - 1);

  // ---------------- update datapath ----------------
  assign acc_val  = {rd_entry.high, rd_entry.low};
  assign row_val  = {item_vh, item_vl};
  assign sum_val  = acc_val + row_val;
  assign sum_wrap = (acc_val[127] == row_val[127]) && (sum_val[127] != row_val[127]);
  assign sum_bad  = sum_wrap || ($signed(sum_val) > $signed(gda_pkg::SUM_MAX)) ||
                    ($signed(sum_val) < $signed(gda_pkg::SUM_MIN));
  assign row_less = $signed(row_val) < $signed(acc_val);
  assign row_more = $signed(row_val) > $signed(acc_val);
  assign do_acc   = (item_kind == gda_pkg::KIND_ACC) && group_ok && !item_null &&
                    !overflow_flag;

  always_comb begin
    do_upd  = 1'b0;
    set_ovf = 1'b0;
    take    = 1'b0;
    new_val = acc_val;
    case (agg_mode)
      gda_pkg::MODE_SUM: begin
        set_ovf = do_acc && sum_bad;
        do_upd  = do_acc && !sum_bad;
        new_val = sum_val;
      end
      gda_pkg::MODE_MIN: begin
        do_upd = do_acc;
        take   = !rd_entry.seen || row_less;
      end
      gda_pkg::MODE_MAX: begin
        do_upd = do_acc;
        take   = !rd_entry.seen || row_more;
      end
      gda_pkg::MODE_FIRST: begin
        do_upd = do_acc;
        take   = !rd_entry.seen;
      end
      gda_pkg::MODE_LAST: begin
        do_upd = do_acc;
        take   = 1'b1;
      end
      default: begin
        do_upd = 1'b0;
      end
    endcase
    if (take) begin
      new_val = row_val;
    end
  end

  always_comb begin
    upd_entry.high  = new_val[127:64];
    upd_entry.low   = new_val[63:0];
    upd_entry.seen  = 1'b1;
    upd_entry.count = (rd_entry.count == '1) ? rd_entry.count : rd_entry.count + 32'd1;
  end

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    case (state)
      gda_pkg::ST_CLEAR: begin
        if (clear_last) state_next = gda_pkg::ST_IDLE;
      end
      gda_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = gda_pkg::ST_APPLY;
      end
      gda_pkg::ST_APPLY: begin
        if (apply_go) state_next = gda_pkg::ST_IDLE;
      end
      default: begin
        state_next = gda_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    apply_go  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = gda_pkg::GROUP_AW'(item_gid);
    ram_wdata = '0;
    ram_raddr = gda_pkg::GROUP_AW'(s_tdata[9:0]);
    case (state)
      gda_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      gda_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        ram_re   = s_tvalid;
      end
      gda_pkg::ST_APPLY: begin
        // hold a read item while the previous result is not taken
        apply_go = !item_is_read || !m_tvalid || m_tready;
        if (do_upd) begin
          ram_we    = apply_go;
          ram_wdata = EW'(upd_entry);
        end else if ((item_kind == gda_pkg::KIND_READ_CLEAR) && group_ok) begin
          ram_we = apply_go;
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gda_pkg::ST_CLEAR;
      clr_addr      <= '0;
      agg_mode      <= gda_pkg::MODE_SUM;
      overflow_flag <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gda_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + gda_pkg::GROUP_AW'(1);
      end
      if (cfg_wr_en) begin
        agg_mode <= cfg_wr_data;
      end
      if (apply_go && set_ovf) begin
        overflow_flag <= 1'b1;
      end
      if (apply_go && item_is_read) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      item_kind <= s_tuser[1:0];
      item_null <= s_tuser[2];
      item_gid  <= s_tdata[9:0];
      item_vh   <= s_tdata[73:10];
      item_vl   <= s_tdata[137:74];
    end
    if (apply_go && item_is_read) begin
      // upper half goes out in the low bits
      m_tdata[127:0]   <= (group_ok && rd_entry.seen) ? {rd_entry.low, rd_entry.high} :
                          128'd0;
      m_tdata[159:128] <= group_ok ? rd_entry.count : 32'd0;
      m_tuser[0]       <= group_ok && rd_entry.seen;
      m_tuser[1]       <= overflow_flag;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == gda_pkg::ST_APPLY)
    else $error("result appeared outside the update cycle");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |=> overflow_flag)
    else $error("overflow flag dropped without reset");

  a_accept_to_apply: assert property (@(posedge clk) disable iff (rst)
    item_accept |=> state == gda_pkg::ST_APPLY)
    else $error("accepted item did not reach the update cycle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state != gda_pkg::ST_IDLE)
    else $error("state RAM written while idle");
`endif

endmodule

// ----- tb/grouped_decimal_aggregator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_decimal_aggregator_test
// Self-checking bench for the per-group decimal aggregator. A queue of row
// and read items feeds a stream driver. A shadow copy of the group table
// predicts every read result, and the output monitor compares each result
// field by field. Items go through directed cases and then random phases in
// each of the five defined modes. The run ends with a sum overflow, which is sticky.
// ----------------------------------------------------------------------------
module grouped_decimal_aggregator_test;

  localparam logic [1:0] KIND_UNDEF = 2'd3;
  localparam logic [2:0] MODE_UNDEF = 3'd7;
  localparam logic signed [127:0] VAL_MAX = {1'b0, {127{1'b1}}};
  localparam logic signed [127:0] VAL_MIN = {1'b1, {127{1'b0}}};

  typedef struct {
    logic [1:0]          kind;
    logic [9:0]          group;
    logic signed [127:0] value;
    logic                is_null;
  } agg_row_t;

  typedef struct {
    logic signed [127:0] value;
    logic                seen;
    logic [31:0]         rows;
    logic                ovf;
  } group_read_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_wr_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;       // group_id, value_high, value_low, zero pad
  logic [2:0]   s_tuser = '0;       // kind, is_null
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;            // result_high, result_low, row_count
  logic [1:0]   m_tuser;            // result_seen, overflowed

  grouped_decimal_aggregator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always #2 clk = ~clk;

  // Shadow of the group table
  logic signed [127:0] grp_value [gda_pkg::GROUPS];
  logic                grp_seen  [gda_pkg::GROUPS];
  logic [31:0]         grp_rows  [gda_pkg::GROUPS];
  logic                sum_overflow = 1'b0;
  logic [2:0]          shadow_mode = gda_pkg::MODE_SUM;

  agg_row_t    rows_to_send [$];
  group_read_t expected_reads [$];
  agg_row_t    row_on_bus;
  int          rows_queued = 0;
  int          rows_taken = 0;
  int          reads_checked = 0;
  int          mismatches = 0;
  bit          bursts_on = 1'b1;

  // Fold one accepted item into the shadow table; queue its read result.
  task automatic fold_row(input agg_row_t r);
    group_read_t         res;
    logic signed [128:0] total;
    logic                take;
    int                  g;
    g = r.group;
    if (r.kind == gda_pkg::KIND_ACC) begin
      if (r.is_null || sum_overflow || g >= gda_pkg::GROUPS) return;
      if (shadow_mode == gda_pkg::MODE_SUM) begin
        total = {grp_value[g][127], grp_value[g]} + {r.value[127], r.value};
        if (total > $signed({gda_pkg::SUM_MAX[127], gda_pkg::SUM_MAX}) ||
            total < $signed({gda_pkg::SUM_MIN[127], gda_pkg::SUM_MIN})) begin
          sum_overflow = 1'b1;
          return;
        end
        grp_value[g] = total[127:0];
      end else if (shadow_mode > gda_pkg::MODE_LAST) begin
        return;
      end else begin
        take = !grp_seen[g] || shadow_mode == gda_pkg::MODE_LAST ||
               (shadow_mode == gda_pkg::MODE_MIN && r.value < grp_value[g]) ||
               (shadow_mode == gda_pkg::MODE_MAX && r.value > grp_value[g]);
        if (take) grp_value[g] = r.value;
      end
      grp_seen[g] = 1'b1;
      if (grp_rows[g] != 32'hFFFF_FFFF) grp_rows[g] = grp_rows[g] + 1;
    end else if (r.kind == gda_pkg::KIND_READ || r.kind == gda_pkg::KIND_READ_CLEAR) begin
      res.value = '0;
      res.seen  = 1'b0;
      res.rows  = '0;
      res.ovf   = sum_overflow;
      if (g < gda_pkg::GROUPS) begin
        if (grp_seen[g]) begin
          res.value = grp_value[g];
          res.seen  = 1'b1;
        end
        res.rows = grp_rows[g];
        if (r.kind == gda_pkg::KIND_READ_CLEAR) begin
          grp_value[g] = '0;
          grp_seen[g]  = 1'b0;
          grp_rows[g]  = '0;
        end
      end
      expected_reads = {expected_reads, res};
    end
  endtask

  // Driver: hold the item until taken, then advance or insert a gap
  int gap_left = 0;
  always @(posedge clk) begin
    logic fire;
    fire = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        fold_row(row_on_bus);
        rows_taken++;
      end
      if (s_tvalid && !fire) begin
        // hold
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (rows_to_send.size() > 0 && bursts_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 2);
        s_tvalid <= 1'b0;
      end else if (rows_to_send.size() > 0) begin
        row_on_bus = rows_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, row_on_bus.value[63:0], row_on_bus.value[127:64],
                     row_on_bus.group};
        s_tuser  <= {row_on_bus.is_null, row_on_bus.kind};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready: short random stalls, plus one long hold-off
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && reads_checked >= 60) begin
      hold_done = 1'b1;
      hold_left = 400;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Monitor
  always @(posedge clk) begin
    group_read_t want;
    if (!rst && m_tvalid && m_tready) begin
      reads_checked++;
      if (expected_reads.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got %h %h", $time, m_tdata,
                 m_tuser);
      end else begin
        want = expected_reads.pop_front();
        check_field("result_high", want.value[127:64], m_tdata[63:0]);
        check_field("result_low", want.value[63:0], m_tdata[127:64]);
        check_field("row_count", 64'(want.rows), 64'(m_tdata[159:128]));
        check_field("result_seen", 64'(want.seen), 64'(m_tuser[0]));
        check_field("overflowed", 64'(want.ovf), 64'(m_tuser[1]));
      end
    end
  end

  function automatic void add_row(input logic [1:0] kind, input int group,
                                  input logic signed [127:0] value,
                                  input logic is_null = 1'b0);
    agg_row_t r;
    r.kind    = kind;
    r.group   = group[9:0];
    r.value   = value;
    r.is_null = is_null;
    rows_to_send = {rows_to_send, r};
    rows_queued++;
  endfunction

  function automatic int pick_group(input bit upper);
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 15);
    return upper ? g + 512 : g;
  endfunction

  // Upper groups take full-range values and are never summed; lower groups
  // take values of at most 101 bits, so sums there cannot overflow.
  function automatic void add_random_rows(input int n, input bit wide);
    logic [127:0] raw;
    logic signed [127:0] v;
    logic [1:0] kind;
    bit upper;
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) kind = KIND_UNDEF;
      else if (pick < 20) kind = gda_pkg::KIND_READ;
      else if (pick < 30) kind = gda_pkg::KIND_READ_CLEAR;
      else kind = gda_pkg::KIND_ACC;
      upper = (kind != gda_pkg::KIND_ACC || wide) ? ($urandom_range(0, 1) == 1) : 1'b0;
      raw = {$urandom, $urandom, $urandom, $urandom};
      if (upper) begin
        case ($urandom_range(0, 9))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = '0;
          3: v = -1;
          default: v = raw;
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0: v = '0;
          1: v = -1;
          2: v = 1;
          default: v = $signed(raw << 27) >>> 27;
        endcase
      end
      add_row(kind, pick_group(upper), v, $urandom_range(0, 9) == 0);
    end
  endfunction

  task automatic set_mode(input logic [2:0] m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_mode = m;
  endtask

  // Wait until every item is taken and every read answered
  task automatic drain();
    while (rows_taken != rows_queued || expected_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < gda_pkg::GROUPS; i++) begin
      grp_value[i] = '0;
      grp_seen[i]  = 1'b0;
      grp_rows[i]  = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Sum basics, null skip, read and clear, undefined kind, untouched group
    set_mode(gda_pkg::MODE_SUM);
    add_row(gda_pkg::KIND_ACC, 0, 123456789);
    add_row(gda_pkg::KIND_ACC, 0, -1000);
    add_row(gda_pkg::KIND_ACC, 0, 5, 1'b1);
    add_row(gda_pkg::KIND_READ, 0, 0);
    add_row(gda_pkg::KIND_ACC, 0, 1);
    add_row(gda_pkg::KIND_READ_CLEAR, 0, 0);
    add_row(gda_pkg::KIND_READ, 0, 0);
    add_row(KIND_UNDEF, 0, 0);
    add_row(gda_pkg::KIND_READ, 1023, 0);
    drain();

    set_mode(gda_pkg::MODE_MIN);
    add_row(gda_pkg::KIND_ACC, 600, VAL_MAX);
    add_row(gda_pkg::KIND_ACC, 600, VAL_MIN);
    add_row(gda_pkg::KIND_ACC, 600, 0);
    add_row(gda_pkg::KIND_READ, 600, 0);
    drain();

    set_mode(gda_pkg::MODE_MAX);
    add_row(gda_pkg::KIND_ACC, 601, VAL_MIN);
    add_row(gda_pkg::KIND_ACC, 601, VAL_MAX);
    add_row(gda_pkg::KIND_ACC, 601, VAL_MAX);
    add_row(gda_pkg::KIND_READ, 601, 0);
    drain();

    set_mode(gda_pkg::MODE_FIRST);
    add_row(gda_pkg::KIND_ACC, 602, 7);
    add_row(gda_pkg::KIND_ACC, 602, -7);
    add_row(gda_pkg::KIND_READ, 602, 0);
    drain();

    set_mode(gda_pkg::MODE_LAST);
    add_row(gda_pkg::KIND_ACC, 1023, VAL_MIN);
    add_row(gda_pkg::KIND_ACC, 1023, 5);
    add_row(gda_pkg::KIND_READ_CLEAR, 1023, 0);
    drain();

    // Undefined mode drops every accumulate row
    set_mode(MODE_UNDEF);
    add_row(gda_pkg::KIND_ACC, 604, 1);
    add_row(gda_pkg::KIND_READ, 604, 0);
    drain();

    set_mode(gda_pkg::MODE_MIN);
    add_random_rows(200, 1'b1);
    drain();
    set_mode(gda_pkg::MODE_SUM);
    add_random_rows(200, 1'b0);
    drain();
    set_mode(gda_pkg::MODE_MAX);
    add_random_rows(200, 1'b1);
    drain();
    set_mode(gda_pkg::MODE_FIRST);
    add_random_rows(200, 1'b1);
    drain();
    set_mode(gda_pkg::MODE_LAST);
    add_random_rows(200, 1'b1);
    drain();

    bursts_on = 1'b0;
    set_mode(gda_pkg::MODE_SUM);
    add_random_rows(200, 1'b0);
    drain();

    // Sums right at both bounds, then one step past a bound
    add_row(gda_pkg::KIND_READ_CLEAR, 5, 0);
    add_row(gda_pkg::KIND_READ_CLEAR, 6, 0);
    add_row(gda_pkg::KIND_ACC, 5, gda_pkg::SUM_MAX);
    add_row(gda_pkg::KIND_ACC, 6, gda_pkg::SUM_MIN);
    add_row(gda_pkg::KIND_READ, 5, 0);
    add_row(gda_pkg::KIND_READ, 6, 0);
    if ($urandom_range(0, 1)) add_row(gda_pkg::KIND_ACC, 5, 1);
    else add_row(gda_pkg::KIND_ACC, 6, -1);
    add_row(gda_pkg::KIND_READ, 5, 0);
    add_row(gda_pkg::KIND_READ, 6, 0);
    add_row(gda_pkg::KIND_ACC, 7, 1);
    add_row(gda_pkg::KIND_READ_CLEAR, 5, 0);
    add_row(gda_pkg::KIND_READ, 5, 0);
    add_row(gda_pkg::KIND_READ, 7, 0);
    drain();

    // Overflow stays set after a switch to min mode
    set_mode(gda_pkg::MODE_MIN);
    add_row(gda_pkg::KIND_ACC, 600, VAL_MIN);
    add_row(gda_pkg::KIND_READ, 600, 0);
    add_random_rows(30, 1'b1);
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
src/gda_pkg.sv
src/gda_ram.sv
src/grouped_decimal_aggregator.sv
tb/grouped_decimal_aggregator_test.sv
